// ===== rtl/sha1_pkg.sv =====
// Package for the SHA-1 stream hasher: constants, types and round helpers.
// Used by every module under rtl; depends on nothing.
package sha1_pkg;
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int FIFO_DEPTH_DEF = 4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
  } core_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    begin
      if (r < 7'd20) k = 32'h5A827999;
      else if (r < 7'd40) k = 32'h6ED9EBA1;
      else if (r < 7'd60) k = 32'h8F1BBCDC;
      else k = 32'hCA62C1D6;
      return k;
    end
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    begin
      if (r < 7'd20) f = (b & c) | (~b & d);
      else if (r < 7'd40 || r >= 7'd60) f = b ^ c ^ d;
      else f = (b & c) | (b & d) | (c & d);
      return f;
    end
  endfunction
endpackage

// ===== rtl/sha1_front.sv =====
// Front part: input queue that accepts and holds items ahead of the core.
// Depends on sha1_pkg.
module sha1_front import sha1_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  take,
  output logic  avail,
  output item_t head
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  item_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;

  assign full  = (cnt == (AW+1)'(DEPTH));
  assign avail = (cnt != '0);
  assign head  = mem[rp];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push && !full) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (take && avail) rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push && !full) - (AW+1)'(take && avail);
    end
  end
endmodule

// ===== rtl/sha1_core.sv =====
// Back part: block buffer, message schedule window and one-round-per-cycle compression.
// Depends on sha1_pkg.
module sha1_core import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        avail,
  input  item_t       head,
  output logic        take,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  core_state_t state, state_next;
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] w [16];
  logic [5:0]  fill;
  logic [63:0] byte_count;
  logic [6:0]  rnd;
  logic        finishing, last_block;
  logic [2:0]  widx;
  logic [5:0]  pad_pos;
  logic        pad_first;

  logic [31:0] tmp, wnew, wcur;
  assign wcur = w[0];
  assign wnew = {w[13]^w[8]^w[2]^w[0]} << 1 | (w[13]^w[8]^w[2]^w[0]) >> 31;
  assign tmp = {a[26:0], a[31:27]} + round_f(rnd, b, c, d) + e + round_k(rnd) + wcur;

  assign empty = (state != ST_EMIT);
  assign digest_word = h[widx];
  assign word_index  = widx;
  assign last_word   = (widx == 3'd4);
  assign take = (state == ST_IDLE) && avail;

  logic [63:0] bits;
  assign bits = {byte_count[60:0], 3'b000};

  function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic first,
                                          input logic lastb, input logic [63:0] bl);
    logic [7:0] v;
    begin
      if (first) v = PAD_BYTE;
      else if (lastb && p >= 6'd56) v = bl[8*(7-(p-6'd56)) +: 8];
      else v = 8'h00;
      return v;
    end
  endfunction

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (avail) state_next = head.mode ? ST_PAD :
                                       (fill == 6'd63 ? ST_ROUND : ST_IDLE);
      ST_PAD:   if (pad_pos == 6'd63) state_next = ST_ROUND;
      ST_ROUND: if (rnd == 7'd79) state_next = ST_FOLD;
      ST_FOLD:  state_next = !finishing ? ST_IDLE : (last_block ? ST_EMIT : ST_PAD);
      ST_EMIT:  if (pop && widx == 3'd4) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic [7:0] byte_in;
  always_comb begin
    if (state == ST_PAD) byte_in = pad_byte(pad_pos, pad_first, last_block, bits);
    else byte_in = head.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
      fill <= '0; byte_count <= '0; rnd <= '0; finishing <= 1'b0;
      last_block <= 1'b0; widx <= '0; pad_pos <= '0; pad_first <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: if (avail) begin
          if (head.mode) begin
            finishing <= 1'b1;
            pad_first <= 1'b1;
            pad_pos <= fill;
            last_block <= (fill < 6'd56);
          end else begin
            w[fill[5:2]] <= {w[fill[5:2]][23:0], byte_in};
            fill <= fill + 1'b1;
            byte_count <= byte_count + 64'd1;
          end
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          rnd <= '0;
        end
        ST_PAD: begin
          w[pad_pos[5:2]] <= {w[pad_pos[5:2]][23:0], byte_in};
          pad_first <= 1'b0;
          pad_pos <= pad_pos + 1'b1;
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          rnd <= '0;
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wnew;
          e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
          rnd <= rnd + 1'b1;
        end
        ST_FOLD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (finishing && !last_block) begin
            last_block <= 1'b1;
            pad_pos <= '0;
          end
          widx <= '0;
        end
        ST_EMIT: if (pop) begin
          if (widx == 3'd4) begin
            h[0] <= IV0; h[1] <= IV1; h[2] <= IV2; h[3] <= IV3; h[4] <= IV4;
            fill <= '0; byte_count <= '0; finishing <= 1'b0; widx <= '0;
          end else begin
            widx <= widx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/sha1_stream_hasher.sv =====
// Top level of the SHA-1 stream hasher: input queue in front of the compression core.
// Depends on sha1_pkg, sha1_front and sha1_core.
// The core takes in a byte item while idle; every 64th byte also runs 80 rounds, one per
// cycle, then a fold step. A finish item is accepted, the block is padded from the fill
// position to its end, then 80 rounds and a fold run; when more than 55 bytes are
// buffered a second block is padded in full and compressed likewise. It then
// holds the five digest words on the result ports until each is popped. The input queue
// keeps accepting bytes while the core compresses, until the queue is full.
module sha1_stream_hasher import sha1_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  item_t in_item, head;
  logic take, avail;
  assign in_item = '{mode: mode, data_byte: data_byte};

  sha1_front #(.DEPTH(FIFO_DEPTH)) u_front (
    .clk, .rst, .push, .push_item(in_item), .full, .take, .avail, .head
  );

  sha1_core u_core (
    .clk, .rst, .avail, .head, .take, .empty, .pop, .digest_word, .word_index, .last_word
  );
endmodule

// ===== bench/testbench.sv =====
// Testbench for sha1_stream_hasher: streams message bytes and finish beats, predicts
// each digest with a local SHA-1 model and checks every popped digest word in order.
// Depends on sha1_pkg and the RTL under rtl.
`timescale 1ns / 1ps

module testbench;
  import sha1_pkg::*;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        mode = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  logic [31:0] hash_h [5];
  logic [7:0]  msg_block [64];
  logic [5:0]  msg_fill;
  logic [63:0] msg_bytes;

  digest_beat_t digest_q [$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;

  sha1_stream_hasher u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode), .data_byte(data_byte),
    .empty(empty), .pop(pop), .digest_word(digest_word), .word_index(word_index),
    .last_word(last_word)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic hash_restart();
    hash_h[0] = 32'h67452301;
    hash_h[1] = 32'hEFCDAB89;
    hash_h[2] = 32'h98BADCFE;
    hash_h[3] = 32'h10325476;
    hash_h[4] = 32'hC3D2E1F0;
    msg_fill = '0;
    msg_bytes = '0;
  endtask

  task automatic hash_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[r];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
  endtask

  task automatic hash_predict(input logic m, input logic [7:0] byte_in);
    logic [63:0] bits;
    int pos;
    digest_beat_t beat;
    if (m == MODE_ABSORB) begin
      msg_block[msg_fill] = byte_in;
      msg_fill = msg_fill + 1'b1;
      msg_bytes = msg_bytes + 1;
      if (msg_fill == 0) hash_compress();
    end else begin
      bits = msg_bytes << 3;
      pos = msg_fill;
      msg_block[pos++] = PAD_BYTE;
      if (pos > 56) begin
        while (pos < 64) msg_block[pos++] = 8'h00;
        hash_compress();
        pos = 0;
      end
      while (pos < 56) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
      hash_compress();
      for (int i = 0; i < 5; i++) begin
        beat.word = hash_h[i];
        beat.index = 3'(i);
        beat.last = (i == 4);
        digest_q.push_back(beat);
      end
      hash_restart();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send_beat(input logic m, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    mode <= m;
    data_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    hash_predict(m, b);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_message(input int len, input bit finish);
    for (int i = 0; i < len; i++) send_beat(MODE_ABSORB, 8'($urandom));
    if (finish) send_beat(MODE_FINISH, 8'($urandom));
  endtask

  always @(negedge clk) pop <= ($urandom_range(99) >= pop_stall_pct);

  always @(posedge clk) begin
    digest_beat_t want;
    cycles <= cycles + 1;
    if (!rst && pop && !empty) begin
      if (digest_q.size() == 0) begin
        report("unexpected digest beat", digest_word, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (digest_word !== want.word) report("digest_word", digest_word, want.word);
        if (word_index !== want.index) report("word_index", 32'(word_index), 32'(want.index));
        if (last_word !== want.last) report("last_word", 32'(last_word), 32'(want.last));
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic test_known_vectors();
    send_beat(MODE_FINISH, 8'hFF);
    send_beat(MODE_FINISH, 8'h00);
    send_beat(MODE_ABSORB, "a");
    send_beat(MODE_ABSORB, "b");
    send_beat(MODE_ABSORB, "c");
    send_beat(MODE_FINISH, 8'h00);
    send_beat(MODE_ABSORB, 8'h00);
    send_beat(MODE_ABSORB, 8'hFF);
    send_beat(MODE_FINISH, 8'hFF);
    wait_drained();
  endtask

  task automatic test_pad_boundaries();
    send_message(55, 1);
    send_message(56, 1);
    send_message(64, 1);
  endtask

  task automatic test_random_messages();
    int len;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 53 : 28) : 0;
      pop_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 53 : 28) : 0;
      for (int m = 0; m < 5; m++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(54, 70) : $urandom_range(0, 12);
        send_message(len, 1);
      end
    end
    send_idle_pct = 0;
    pop_stall_pct = 0;
  endtask

  initial begin
    hash_restart();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_known_vectors();
    test_pad_boundaries();
    test_random_messages();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/sha1_pkg.sv
rtl/sha1_front.sv
rtl/sha1_core.sv
rtl/sha1_stream_hasher.sv
bench/testbench.sv
